### hw/rtl/kdlr_pkg.sv
package kdlr_pkg;

  localparam int NUM_KEYS = 4;
  localparam int KEY_W = 2;
  localparam int KEY_SLOTS = 1 << KEY_W;

  localparam int FILTER_W = 7;
  localparam int COUNT_W = 8;
  localparam int HOLD_W = 16;
  localparam int RPT_W = 8;
  localparam int LONG_PACK_W = 64;
  localparam int RPT_PACK_W = 32;
  localparam int CFG_W = 64;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT = 2'd2;

  localparam logic [FILTER_W-1:0] FILTER_RESET = 7'd5;
  localparam logic [LONG_PACK_W-1:0] LONG_RESET = 64'd28147927174348900;
  localparam logic [RPT_PACK_W-1:0] REPEAT_RESET = 32'd0;

  typedef struct packed {
    logic [COUNT_W-1:0] filter_count;
    logic               stable_state;
    logic [HOLD_W-1:0]  hold_count;
    logic [RPT_W-1:0]   repeat_count;
  } key_state_t;

  typedef struct packed {
    logic debounced_pressed;
    logic press_event;
    logic release_event;
    logic long_event;
  } key_result_t;

endpackage

### hw/rtl/kdlr_key_logic.sv
module kdlr_key_logic (
  input  logic [kdlr_pkg::FILTER_W-1:0]    filter_ticks,
  input  logic [kdlr_pkg::LONG_PACK_W-1:0] long_times_packed,
  input  logic [kdlr_pkg::RPT_PACK_W-1:0]  repeat_speeds_packed,
  input  logic [kdlr_pkg::KEY_W-1:0]       key,
  input  logic                             raw,
  input  kdlr_pkg::key_state_t             cur,
  output kdlr_pkg::key_state_t             nxt,
  output kdlr_pkg::key_result_t            res
);
  import kdlr_pkg::*;

  logic [COUNT_W-1:0] f_ext;
  logic [COUNT_W-1:0] f_dbl;
  logic [HOLD_W-1:0]  long_time;
  logic [RPT_W-1:0]   rpt_speed;
  logic [HOLD_W-1:0]  hold_inc;
  logic [RPT_W-1:0]   rpt_inc;

  assign f_ext = {1'b0, filter_ticks};
  assign f_dbl = {filter_ticks, 1'b0};
  assign long_time = long_times_packed[HOLD_W*key +: HOLD_W];
  assign rpt_speed = repeat_speeds_packed[RPT_W*key +: RPT_W];
  assign hold_inc = cur.hold_count + HOLD_W'(1);
  assign rpt_inc = cur.repeat_count + RPT_W'(1);

  always_comb begin
    nxt = cur;
    res = '0;
    if (raw) begin
      if (cur.filter_count < f_ext) begin
        nxt.filter_count = f_ext;
      end else if (cur.filter_count < f_dbl) begin
        nxt.filter_count = cur.filter_count + COUNT_W'(1);
      end else begin
        if (!cur.stable_state) begin
          nxt.stable_state = 1'b1;
          res.press_event = 1'b1;
        end
        if (long_time != '0) begin
          if (cur.hold_count < long_time) begin
            nxt.hold_count = hold_inc;
            res.long_event = (hold_inc == long_time);
          end else if (rpt_speed != '0) begin
            nxt.repeat_count = rpt_inc;
            if (rpt_inc >= rpt_speed) begin
              nxt.repeat_count = '0;
              res.press_event = 1'b1;
            end
          end
        end
      end
    end else begin
      if (cur.filter_count > f_ext) begin
        nxt.filter_count = f_ext;
      end else if (cur.filter_count != '0) begin
        nxt.filter_count = cur.filter_count - COUNT_W'(1);
      end else if (cur.stable_state) begin
        nxt.stable_state = 1'b0;
        res.release_event = 1'b1;
      end
      nxt.hold_count = '0;
      nxt.repeat_count = '0;
    end
    res.debounced_pressed = nxt.stable_state;
  end

endmodule

### hw/rtl/key_debounce_long_repeat_unit.sv
// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_stall   key_index, raw_pressed
// result    out        out_valid / out_stall key_number, debounced_pressed, press_event,
//                                            release_event, long_event
// config    in         cfg_write             cfg_index, cfg_data
//
// An accepted item waits in the input register while the per-key update works on
// it, and then moves into the result register, from which its result is taken.
// A new item is accepted every cycle unless the result register is stalled with
// the input register full; consecutive items for the same key are fine because
// the key state is written in the same edge that loads the result.
// Reset restores the register defaults and sets every filter counter to half
// the default filter time. A stalled result holds the pipeline; the input side
// keeps accepting until the input register is also full.
module key_debounce_long_repeat_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [kdlr_pkg::KEY_W-1:0]      key_index,
  input  logic                            raw_pressed,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [kdlr_pkg::KEY_W-1:0]      key_number,
  output logic                            debounced_pressed,
  output logic                            press_event,
  output logic                            release_event,
  output logic                            long_event,
  input  logic                            cfg_write,
  input  logic [kdlr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kdlr_pkg::CFG_W-1:0]      cfg_data
);
  import kdlr_pkg::*;

  // Configuration registers.
  logic [FILTER_W-1:0]    filter_ticks;
  logic [LONG_PACK_W-1:0] long_times_packed;
  logic [RPT_PACK_W-1:0]  repeat_speeds_packed;
  logic                   clear_repeat;

  // Per-key state, one entry per possible key index.
  key_state_t key_state [KEY_SLOTS];

  // Input register.
  logic             s1_valid;
  logic [KEY_W-1:0] s1_key;
  logic             s1_raw;

  // Result register.
  logic             res_valid;
  logic [KEY_W-1:0] res_key;
  key_result_t      res_data;

  logic        advance;
  logic        accept;
  logic        key_ok;
  key_state_t  cur_state;
  key_state_t  nxt_state;
  key_result_t step_res;

  assign advance = !res_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  assign accept = in_valid && !in_stall;

  // A key index beyond the configured key count leaves all state alone
  // and reports zero flags.
  assign key_ok = ({1'b0, s1_key} < (KEY_W+1)'(NUM_KEYS));
  assign cur_state = key_state[s1_key];

  kdlr_key_logic u_key_logic (
    .filter_ticks         (filter_ticks),
    .long_times_packed    (long_times_packed),
    .repeat_speeds_packed (repeat_speeds_packed),
    .key                  (s1_key),
    .raw                  (s1_raw),
    .cur                  (cur_state),
    .nxt                  (nxt_state),
    .res                  (step_res)
  );

  // Writing either per-key lane register restarts every auto-repeat period.
  assign clear_repeat = cfg_write && (cfg_index == REG_LONG || cfg_index == REG_REPEAT);

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_ticks <= FILTER_RESET;
      long_times_packed <= LONG_RESET;
      repeat_speeds_packed <= REPEAT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FILTER: filter_ticks <= cfg_data[FILTER_W-1:0];
        REG_LONG:   long_times_packed <= cfg_data[LONG_PACK_W-1:0];
        REG_REPEAT: repeat_speeds_packed <= cfg_data[RPT_PACK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < KEY_SLOTS; k++) begin
        key_state[k].filter_count <= COUNT_W'(FILTER_RESET >> 1);
        key_state[k].stable_state <= 1'b0;
        key_state[k].hold_count <= '0;
        key_state[k].repeat_count <= '0;
      end
    end else begin
      for (int k = 0; k < KEY_SLOTS; k++) begin
        if (s1_valid && advance && key_ok && s1_key == KEY_W'(k)) begin
          key_state[k].filter_count <= nxt_state.filter_count;
          key_state[k].stable_state <= nxt_state.stable_state;
          key_state[k].hold_count <= nxt_state.hold_count;
          key_state[k].repeat_count <= clear_repeat ? '0 : nxt_state.repeat_count;
        end else if (clear_repeat) begin
          key_state[k].repeat_count <= '0;
        end
      end
    end
  end

  // Input register stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_key <= key_index;
      s1_raw <= raw_pressed;
    end
  end

  // Result register stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      res_key <= s1_key;
      res_data <= key_ok ? step_res : '0;
    end
  end

  assign out_valid = res_valid;
  assign key_number = res_key;
  assign debounced_pressed = res_data.debounced_pressed;
  assign press_event = res_data.press_event;
  assign release_event = res_data.release_event;
  assign long_event = res_data.long_event;

`ifndef SYNTHESIS
  a_press_release_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(press_event && release_event))
    else $error("press and release flagged in the same item");

  a_long_needs_pressed: assert property (@(posedge clk) disable iff (rst)
    (out_valid && long_event) |-> debounced_pressed)
    else $error("long press flagged while key is released");

  a_release_state: assert property (@(posedge clk) disable iff (rst)
    (out_valid && release_event) |-> !debounced_pressed)
    else $error("release flagged while key is pressed");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && res_valid && out_stall))
    else $error("input stalled with room in the pipeline");
`endif

endmodule
